// File: rtl/core/pbaw_pkg.sv
// Shared types, constants, microcode table and helpers for the PID anti-windup controller.
package pbaw_pkg;

    // Data widths
    localparam int DATA_W        = 32;
    localparam int MUL_A_W       = DATA_W + 1;
    localparam int PROD_W        = MUL_A_W + DATA_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int STEP_W        = 4;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd5;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // Microprogram addresses
    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_I    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADD_I    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SAT_I    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADD_P    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADD_D    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RAW      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CLAMP    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_BACK     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MUL_B    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ADD_B    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAST     = STEP_FINISH;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } t_clamp;

    typedef enum logic [1:0] {
        MA_ERR  = 2'd0,
        MA_DIFF = 2'd1,
        MA_BACK = 2'd2
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_GAIN_I    = 2'd0,
        MB_GAIN_P    = 2'd1,
        MB_GAIN_D    = 2'd2,
        MB_GAIN_BACK = 2'd3
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LD_INT = 2'd1,
        ACC_ADD    = 2'd2,
        ACC_LD_SAT = 2'd3
    } t_acc_op;

    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_WAIT_IN  = 2'd1,
        JMP_WAIT_OUT = 2'd2
    } t_jmp;

    // One control word per microprogram step
    typedef struct packed {
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        logic    mul_en;
        t_acc_op acc_op;
        logic    int_we;
        logic    diff_en;
        logic    raw_en;
        logic    clamp_en;
        logic    back_en;
        logic    done;
        t_jmp    jmp;
    } t_ctrl;

    // Handshake status seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic out_free;
    } t_stat;

    localparam t_ctrl CTRL_NOP = '{
        mul_a: MA_ERR, mul_b: MB_GAIN_I, mul_en: 1'b0, acc_op: ACC_HOLD,
        int_we: 1'b0, diff_en: 1'b0, raw_en: 1'b0, clamp_en: 1'b0,
        back_en: 1'b0, done: 1'b0, jmp: JMP_NEXT
    };

    // Microcode ROM
    function automatic t_ctrl ucode_word(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = CTRL_NOP;
        case (step)
            STEP_IDLE: begin
                c.jmp = JMP_WAIT_IN;
            end
            STEP_MUL_I: begin
                c.mul_a   = MA_ERR;
                c.mul_b   = MB_GAIN_I;
                c.mul_en  = 1'b1;
                c.acc_op  = ACC_LD_INT;
                c.diff_en = 1'b1;
            end
            STEP_ADD_I: begin
                c.acc_op = ACC_ADD;
            end
            STEP_SAT_I: begin
                c.acc_op = ACC_LD_SAT;
                c.int_we = 1'b1;
                c.mul_a  = MA_ERR;
                c.mul_b  = MB_GAIN_P;
                c.mul_en = 1'b1;
            end
            STEP_ADD_P: begin
                c.acc_op = ACC_ADD;
                c.mul_a  = MA_DIFF;
                c.mul_b  = MB_GAIN_D;
                c.mul_en = 1'b1;
            end
            STEP_ADD_D: begin
                c.acc_op = ACC_ADD;
            end
            STEP_RAW: begin
                c.raw_en = 1'b1;
            end
            STEP_CLAMP: begin
                c.clamp_en = 1'b1;
            end
            STEP_BACK: begin
                c.back_en = 1'b1;
                c.acc_op  = ACC_LD_INT;
            end
            STEP_MUL_B: begin
                c.mul_a  = MA_BACK;
                c.mul_b  = MB_GAIN_BACK;
                c.mul_en = 1'b1;
            end
            STEP_ADD_B: begin
                c.acc_op = ACC_ADD;
            end
            STEP_FINISH: begin
                c.int_we = 1'b1;
                c.done   = 1'b1;
                c.jmp    = JMP_WAIT_OUT;
            end
            default: begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

    // Saturate a wide signed value to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return S32_MIN;
        end else begin
            return S32_MAX;
        end
    endfunction

endpackage

// File: rtl/core/pbaw_mul.sv
// Shared signed multiplier with registered, floor-scaled product.
module pbaw_mul #(
    parameter int FRAC_BITS = pbaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [pbaw_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [pbaw_pkg::DATA_W-1:0]  i_b,
    output logic signed [pbaw_pkg::PROD_W-1:0]  o_prod
);

    logic signed [pbaw_pkg::PROD_W-1:0] full_prod;
    logic signed [pbaw_pkg::PROD_W-1:0] r_prod;

    assign full_prod = i_a * i_b;

    // Arithmetic shift gives rounding toward negative infinity
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= full_prod >>> FRAC_BITS;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/pbaw_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module pbaw_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pbaw_pkg::t_stat             i_stat,
    output pbaw_pkg::t_ctrl             o_ctrl,
    output logic                        o_idle
);

    logic [pbaw_pkg::STEP_W-1:0] r_step;
    logic [pbaw_pkg::STEP_W-1:0] n_step;
    pbaw_pkg::t_ctrl             ctrl;

    assign ctrl   = pbaw_pkg::ucode_word(r_step);
    assign o_ctrl = ctrl;
    assign o_idle = (r_step == pbaw_pkg::STEP_IDLE);

    // Next step address
    always_comb begin
        case (ctrl.jmp)
            pbaw_pkg::JMP_NEXT: begin
                n_step = r_step + 1'b1;
            end
            pbaw_pkg::JMP_WAIT_IN: begin
                n_step = i_stat.in_fire ? r_step + 1'b1 : r_step;
            end
            pbaw_pkg::JMP_WAIT_OUT: begin
                n_step = i_stat.out_free ? pbaw_pkg::STEP_IDLE : r_step;
            end
            default: begin
                n_step = pbaw_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pbaw_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Program counter stays inside the program
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= pbaw_pkg::STEP_LAST)
        else $error("step counter beyond last microcode step");

    // An accepted item starts the program
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.in_fire |=> r_step == pbaw_pkg::STEP_MUL_I)
        else $error("accepted item did not start the program");

    // Finish step holds while the output register is full
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.jmp == pbaw_pkg::JMP_WAIT_OUT && !i_stat.out_free) |=> $stable(r_step))
        else $error("finish step left with output register full");

    // Only the idle step takes items
    a_fire_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.in_fire |-> r_step == pbaw_pkg::STEP_IDLE)
        else $error("item accepted outside the idle step");

endmodule

// File: rtl/core/pbaw_datapath.sv
// Datapath: config registers, error, accumulator, clamp and controller state.
module pbaw_datapath #(
    parameter int FRAC_BITS = pbaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pbaw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pbaw_pkg::DATA_W-1:0]           i_cfg_data,
    input  logic                                  i_load,
    input  logic signed [pbaw_pkg::DATA_W-1:0]    i_target,
    input  logic signed [pbaw_pkg::DATA_W-1:0]    i_measured,
    input  pbaw_pkg::t_ctrl                       i_ctrl,
    output logic signed [pbaw_pkg::DATA_W-1:0]    o_drive,
    output pbaw_pkg::t_clamp                      o_clamp_state
);

    localparam int DW = pbaw_pkg::DATA_W;
    localparam int AW = pbaw_pkg::ACC_W;

    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d, r_gain_back;
    logic signed [DW-1:0] r_limit_high, r_limit_low;
    logic signed [DW-1:0] r_int, r_prev;
    logic signed [DW-1:0] r_err, r_raw, r_drive;
    logic signed [DW:0]   r_diff, r_back;
    logic signed [AW-1:0] r_acc;
    pbaw_pkg::t_clamp     r_clamp;

    logic signed [pbaw_pkg::MUL_A_W-1:0] mul_a;
    logic signed [DW-1:0]                mul_b;
    logic signed [pbaw_pkg::PROD_W-1:0]  prod;
    logic signed [AW-1:0]                err_wide;
    logic signed [DW-1:0]                acc_sat;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_gain_back  <= '0;
            r_limit_high <= pbaw_pkg::S32_MAX;
            r_limit_low  <= pbaw_pkg::S32_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbaw_pkg::REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                pbaw_pkg::REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                pbaw_pkg::REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                pbaw_pkg::REG_GAIN_BACK:  r_gain_back  <= i_cfg_data;
                pbaw_pkg::REG_LIMIT_HIGH: r_limit_high <= i_cfg_data;
                pbaw_pkg::REG_LIMIT_LOW:  r_limit_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection
    always_comb begin
        case (i_ctrl.mul_a)
            pbaw_pkg::MA_ERR:  mul_a = pbaw_pkg::MUL_A_W'(r_err);
            pbaw_pkg::MA_DIFF: mul_a = r_diff;
            pbaw_pkg::MA_BACK: mul_a = r_back;
            default:           mul_a = '0;
        endcase
        case (i_ctrl.mul_b)
            pbaw_pkg::MB_GAIN_I:    mul_b = r_gain_i;
            pbaw_pkg::MB_GAIN_P:    mul_b = r_gain_p;
            pbaw_pkg::MB_GAIN_D:    mul_b = r_gain_d;
            pbaw_pkg::MB_GAIN_BACK: mul_b = r_gain_back;
            default:                mul_b = '0;
        endcase
    end

    pbaw_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (i_ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign err_wide = AW'(i_target) - AW'(i_measured);
    assign acc_sat  = pbaw_pkg::sat32(r_acc);

    // Error capture and difference
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err <= pbaw_pkg::sat32(err_wide);
        end
        if (i_ctrl.diff_en) begin
            r_diff <= (DW+1)'(r_err) - (DW+1)'(r_prev);
        end
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        case (i_ctrl.acc_op)
            pbaw_pkg::ACC_LD_INT: r_acc <= AW'(r_int);
            pbaw_pkg::ACC_ADD:    r_acc <= r_acc + AW'(prod);
            pbaw_pkg::ACC_LD_SAT: r_acc <= AW'(acc_sat);
            default:              r_acc <= r_acc;
        endcase
    end

    // Raw output, clamp and back-calculation difference
    always_ff @(posedge i_clk) begin
        if (i_ctrl.raw_en) begin
            r_raw <= acc_sat;
        end
        if (i_ctrl.clamp_en) begin
            // high test wins when the limits are inverted
            if (r_raw > r_limit_high) begin
                r_drive <= r_limit_high;
                r_clamp <= pbaw_pkg::CLAMP_HIGH;
            end else if (r_raw < r_limit_low) begin
                r_drive <= r_limit_low;
                r_clamp <= pbaw_pkg::CLAMP_LOW;
            end else begin
                r_drive <= r_raw;
                r_clamp <= pbaw_pkg::CLAMP_NONE;
            end
        end
        if (i_ctrl.back_en) begin
            r_back <= (DW+1)'(r_drive) - (DW+1)'(r_raw);
        end
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_prev <= '0;
        end else begin
            if (i_ctrl.int_we) begin
                r_int <= acc_sat;
            end
            if (i_ctrl.done) begin
                r_prev <= r_err;
            end
        end
    end

    assign o_drive       = r_drive;
    assign o_clamp_state = r_clamp;

endmodule

// File: rtl/core/pid_backcalc_antiwindup.sv
// Top level of the positional PID controller with back-calculation anti-windup.
// Items are processed one at a time: a new item is accepted only in the idle step, after the previous one finished.
// The rate is set by the microprogram length on one shared multiplier.
// A finished result waits in the output register; the next item is taken meanwhile.
// Synchronous active-low reset: gains 0, limits at the 32-bit extremes,
// integral and previous error cleared, output empty.
module pid_backcalc_antiwindup #(
    parameter int FRAC_BITS = pbaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [pbaw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pbaw_pkg::DATA_W-1:0]          i_cfg_data,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pbaw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // target[31:0], measured[63:32]
    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [pbaw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // drive[31:0], clamp_state[33:32]
);

    localparam int DW = pbaw_pkg::DATA_W;

    pbaw_pkg::t_ctrl  ctrl;
    pbaw_pkg::t_stat  stat;
    pbaw_pkg::t_clamp clamp_state;
    logic             idle;
    logic signed [DW-1:0] drive;

    logic                                r_m_valid;
    logic [pbaw_pkg::OUT_TDATA_W-1:0]    r_m_data;

    assign s_axis_tready = idle;
    assign stat.in_fire  = s_axis_tvalid && idle;
    assign stat.out_free = !r_m_valid || m_axis_tready;

    pbaw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_idle  (idle)
    );

    pbaw_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_load        (stat.in_fire),
        .i_target      (s_axis_tdata[DW-1:0]),
        .i_measured    (s_axis_tdata[2*DW-1:DW]),
        .i_ctrl        (ctrl),
        .o_drive       (drive),
        .o_clamp_state (clamp_state)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (ctrl.done && stat.out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.done && stat.out_free) begin
            r_m_data <= pbaw_pkg::OUT_TDATA_W'({clamp_state, drive});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
